// File: sv/csfw_pkg.sv
// package for the counting semaphore with fifo waiters
// types, codes and default sizes shared by the interfaces and modules

package csfw_pkg;

  localparam int MAX_TASKS_DEF   = 16;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam int TASK_W = 4;
  localparam int MASK_W = 16;
  localparam int CFG_W  = 16;

  localparam logic FUNC_WAIT   = 1'b0;
  localparam logic FUNC_SIGNAL = 1'b1;

  localparam logic [1:0] REG_INITIAL_COUNT = 2'd0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HEAD,
    ST_SCAN,
    ST_EMIT
  } csfw_state_t;

  // queue commands from the sequencer
  typedef struct packed {
    logic clear;
    logic pop;
    logic push;
    logic scan_start;
    logic scan_step;
  } csfw_qctl_t;

endpackage

// File: sv/csfw_cmd_if.sv
// command channel: one semaphore operation per beat
// depends on csfw_pkg

interface csfw_cmd_if
  import csfw_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              func;
  logic [TASK_W-1:0] task_id;
  logic [MASK_W-1:0] live_mask;
  logic [MASK_W-1:0] blocked_mask;

  modport source (output valid, func, task_id, live_mask, blocked_mask, input ready);
  modport sink   (input valid, func, task_id, live_mask, blocked_mask, output ready);
endinterface

// File: sv/csfw_res_if.sv
// result channel: one result per command beat
// depends on csfw_pkg

interface csfw_res_if
  import csfw_pkg::*;
#(
  parameter int LEN_W = 5,
  parameter int CNT_W = COUNT_WIDTH_DEF
) ();
  logic              valid;
  logic              ready;
  logic              granted;
  logic              caller_blocked;
  logic              wake_valid;
  logic [TASK_W-1:0] wake_task;
  logic [LEN_W-1:0]  waiter_count;
  logic [CNT_W-1:0]  sem_count;

  modport source (output valid, granted, caller_blocked, wake_valid, wake_task,
                  waiter_count, sem_count, input ready);
  modport sink   (input valid, granted, caller_blocked, wake_valid, wake_task,
                  waiter_count, sem_count, output ready);
endinterface

// File: sv/csfw_queue.sv
// circular waiter queue: memory, head pointer, length and scan pointer
// depends on csfw_pkg; driven by the sequencer in the top level

module csfw_queue
  import csfw_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEF,
  localparam int IDX_W = $clog2(MAX_TASKS),
  localparam int LEN_W = $clog2(MAX_TASKS + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  csfw_qctl_t        ctl,
  input  logic [TASK_W-1:0] wr_data,
  output logic [TASK_W-1:0] rd_data,
  output logic [LEN_W-1:0]  len
);

  logic [TASK_W-1:0] mem [MAX_TASKS];
  logic [IDX_W-1:0]  head;
  logic [IDX_W-1:0]  scan_addr;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  tail;
  logic [IDX_W:0]    tail_sum;

  function automatic logic [IDX_W-1:0] ptr_inc(input logic [IDX_W-1:0] p);
    ptr_inc = (p == IDX_W'(MAX_TASKS - 1)) ? '0 : p + 1'b1;
  endfunction

  assign tail_sum = {1'b0, head} + (IDX_W + 1)'(len);
  assign tail = (tail_sum >= (IDX_W + 1)'(MAX_TASKS)) ?
                IDX_W'(tail_sum - (IDX_W + 1)'(MAX_TASKS)) : IDX_W'(tail_sum);

  // read the entry the sequencer looks at next cycle
  always_comb begin
    if (ctl.scan_step) begin
      rd_addr = ptr_inc(scan_addr);
    end else if (ctl.pop || ctl.scan_start) begin
      rd_addr = ptr_inc(head);
    end else begin
      rd_addr = head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      head <= '0;
      len  <= '0;
    end else if (ctl.pop) begin
      head <= ptr_inc(head);
      len  <= len - 1'b1;
    end else if (ctl.push) begin
      len  <= len + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.scan_start) begin
      scan_addr <= ptr_inc(head);
    end else if (ctl.scan_step) begin
      scan_addr <= ptr_inc(scan_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: sv/counting_semaphore_fifo_waiters.sv
// counting semaphore with a fair fifo of waiting task ids, apb config port
// depends on csfw_pkg, csfw_cmd_if, csfw_res_if and csfw_queue
//
//  channel  dir  handshake      beat
//  cmd      in   valid/ready    func, task_id, live_mask, blocked_mask
//  res      out  valid/ready    granted, caller_blocked, wake_valid, wake_task,
//                               waiter_count, sem_count
//  apb      in   psel/penable   initial_count at every address, pready tied high
//
// a command goes through the head state, then the emit state; on the way
// a wait that fails scans the queue one entry a cycle in the scan state, and
// a signal pops dead head waiters one a cycle in the head state; the single
// read port of the queue memory sets this pace. cmd.ready is high only while the
// sequencer is idle, and a new command is taken while the last result still sits in
// the output register; a held result stalls the sequencer in its emit state.
// rst is synchronous: count goes to 0, queue empties, no memory clearing pass.
// writing initial_count reloads the count (clamped) and empties the queue.

module counting_semaphore_fifo_waiters
  import csfw_pkg::*;
#(
  parameter int MAX_TASKS   = MAX_TASKS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
  localparam int LEN_W = $clog2(MAX_TASKS + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [1:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  csfw_cmd_if.sink          cmd,
  csfw_res_if.source        res
);

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [31:0] CNT_MAX32 = 32'((64'd1 << COUNT_WIDTH) - 64'd1);

  csfw_state_t state, state_next;
  csfw_qctl_t  qctl;

  // config register and semaphore count
  logic [CFG_W-1:0]       initial_count;
  logic [COUNT_WIDTH-1:0] count_value;
  logic [COUNT_WIDTH-1:0] count_load;
  logic [31:0]            cfg_wide;
  logic                   cfg_we;

  // latched command
  logic              item_func;
  logic [TASK_W-1:0] item_task;
  logic [MASK_W-1:0] item_live;
  logic [MASK_W-1:0] item_blk;

  // working result flags
  logic              r_granted;
  logic              r_blocked;
  logic              r_wake;
  logic [TASK_W-1:0] r_wake_task;

  // queue view
  logic [TASK_W-1:0] rd_data;
  logic [LEN_W-1:0]  len;
  logic [LEN_W-1:0]  scan_pos;

  // sequencer decisions
  logic accept;
  logic out_free;
  logic cnt_dec;
  logic set_grant;
  logic set_block;
  logic set_wake;
  logic emit;
  logic is_head;
  logic scan_hit;
  logic scan_last;

  assign pready   = 1'b1;
  assign prdata   = 32'(initial_count);
  assign cfg_we   = psel && penable && pwrite && (paddr[1:0] == REG_INITIAL_COUNT ||
                    paddr[1:0] != REG_INITIAL_COUNT);
  assign cfg_wide = {16'd0, pwdata[CFG_W-1:0]};
  assign count_load = (cfg_wide > CNT_MAX32) ? CNT_MAX : COUNT_WIDTH'(cfg_wide);

  assign cmd.ready = (state == ST_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign out_free  = !res.valid || res.ready;

  assign is_head   = (len != '0) && (rd_data == item_task);
  assign scan_hit  = (rd_data == item_task);
  assign scan_last = ((scan_pos + 1'b1) == len);

  csfw_queue #(
    .MAX_TASKS (MAX_TASKS)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .ctl     (qctl),
    .wr_data (item_task),
    .rd_data (rd_data),
    .len     (len)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_HEAD;
      end
      ST_HEAD: begin
        if (item_func == FUNC_WAIT) begin
          if (count_value != '0 && (len == '0 || is_head)) begin
            state_next = ST_EMIT;
          end else if (is_head || len == LEN_W'(MAX_TASKS) || len <= LEN_W'(1)) begin
            state_next = ST_EMIT;
          end else begin
            state_next = ST_SCAN;
          end
        end else begin
          // stay here while dead waiters are popped off the head
          if (len == '0 || item_live[rd_data]) state_next = ST_EMIT;
        end
      end
      ST_SCAN: begin
        if (scan_hit || scan_last) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    qctl       = '0;
    qctl.clear = cfg_we;
    cnt_dec    = 1'b0;
    set_grant  = 1'b0;
    set_block  = 1'b0;
    set_wake   = 1'b0;
    emit       = 1'b0;
    unique case (state)
      ST_IDLE: ;
      ST_HEAD: begin
        if (item_func == FUNC_WAIT) begin
          if (count_value != '0 && (len == '0 || is_head)) begin
            cnt_dec   = 1'b1;
            set_grant = 1'b1;
            qctl.pop  = is_head;
          end else begin
            set_block = 1'b1;
            if (!is_head && len != LEN_W'(MAX_TASKS)) begin
              // empty or single foreign entry: append now, else search the rest
              if (len <= LEN_W'(1)) qctl.push = 1'b1;
              else qctl.scan_start = 1'b1;
            end
          end
        end else if (len != '0) begin
          if (!item_live[rd_data]) qctl.pop = 1'b1;
          else set_wake = item_blk[rd_data];
        end
      end
      ST_SCAN: begin
        if (!scan_hit) begin
          if (scan_last) qctl.push = 1'b1;
          else qctl.scan_step = 1'b1;
        end
      end
      ST_EMIT: begin
        emit = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_count <= '0;
      count_value   <= '0;
    end else if (cfg_we) begin
      initial_count <= pwdata[CFG_W-1:0];
      count_value   <= count_load;
    end else if (accept && cmd.func == FUNC_SIGNAL && count_value != CNT_MAX) begin
      count_value <= count_value + 1'b1;
    end else if (cnt_dec) begin
      count_value <= count_value - 1'b1;
    end
  end

  // command latch and per-item flags
  always_ff @(posedge clk) begin
    if (accept) begin
      item_func   <= cmd.func;
      item_task   <= cmd.task_id;
      item_live   <= cmd.live_mask;
      item_blk    <= cmd.blocked_mask;
      r_granted   <= 1'b0;
      r_blocked   <= 1'b0;
      r_wake      <= 1'b0;
      r_wake_task <= '0;
    end else begin
      if (set_grant) r_granted <= 1'b1;
      if (set_block) r_blocked <= 1'b1;
      if (set_wake) begin
        r_wake      <= 1'b1;
        r_wake_task <= rd_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (qctl.scan_start) begin
      scan_pos <= LEN_W'(1);
    end else if (qctl.scan_step) begin
      scan_pos <= scan_pos + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (emit) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res.granted        <= r_granted;
      res.caller_blocked <= r_blocked;
      res.wake_valid     <= r_wake;
      res.wake_task      <= r_wake_task;
      res.waiter_count   <= len;
      res.sem_count      <= count_value;
    end
  end

`ifndef SYNTHESIS
  // a wait result never both grants and blocks
  a_grant_xor_block: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !(res.granted && res.caller_blocked))
    else $error("granted and caller_blocked both set");

  // a wake comes only from a signal, which carries no wait flags
  a_wake_signal_only: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.wake_valid) |-> (!res.granted && !res.caller_blocked))
    else $error("wake reported on a wait result");

  // queue length stays within the memory depth
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= LEN_W'(MAX_TASKS))
    else $error("waiter queue overflow");

  // the sequencer drops ready right after taking a command
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !cmd.ready)
    else $error("command taken while busy");
`endif

endmodule

// File: dv/counting_semaphore_fifo_waiters_tb.sv
// self-checking bench for the counting semaphore with fifo waiters
// depends on csfw_pkg, csfw_cmd_if, csfw_res_if and the block under sv/
// directed table first, then randomized phases checked against a behavioral model
`timescale 1ns / 100ps

module counting_semaphore_fifo_waiters_tb;
  import csfw_pkg::*;

  localparam int             TIMEOUT_NS      = 400_000;
  localparam int             N_PHASES        = 6;
  localparam int             ITEMS_PER_PHASE = 80;
  localparam int             HOLD_CYCLES     = 150;
  // room for the worst command, one that pops a full queue
  localparam int             DRAIN_CYCLES    = 2 * MAX_TASKS_DEF + 8;
  localparam logic [15:0]    COUNT_MAX       = 16'hFFFF;
  localparam logic [1:0]     INIT_COUNT_ADDR = 2'(4 * REG_INITIAL_COUNT);

  typedef struct packed {
    logic              func;
    logic [TASK_W-1:0] task_id;
    logic [MASK_W-1:0] live_mask;
    logic [MASK_W-1:0] blocked_mask;
  } sem_op_t;

  typedef struct packed {
    logic              granted;
    logic              caller_blocked;
    logic              wake_valid;
    logic [TASK_W-1:0] wake_task;
    logic [4:0]        waiter_count;
    logic [15:0]       sem_count;
  } sem_result_t;

  typedef enum logic {ROW_OP, ROW_CFG} row_kind_e;

  // one directed row: an operation beat or a register write;
  // typed rows carry a hand-written result, the rest go through the model
  typedef struct packed {
    row_kind_e   kind;
    sem_op_t     op;
    logic [15:0] cfg_value;
    logic        typed;
    sem_result_t want;
  } dir_row_t;

  localparam int N_DIR = 28;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  csfw_cmd_if cmd_ch ();
  csfw_res_if res_ch ();

  counting_semaphore_fifo_waiters DUT (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cmd     (cmd_ch),
    .res     (res_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // model state: count, fifo of waiting ids and its length
  logic [15:0]       sem_val = '0;
  logic [TASK_W-1:0] waiters [MAX_TASKS_DEF];
  int                n_waiters = 0;

  sem_result_t pending_results [$];

  // knobs shared with the result side, written by the stimulus process only
  int idle_pct    = 29;
  int holds_asked = 0;

  // bookkeeping
  int fail_count  = 0;
  int ops_sent    = 0;
  int results_ok  = 0;
  int n_granted   = 0;
  int n_blocked   = 0;
  int n_wakes     = 0;
  int n_saturated = 0;
  int max_depth   = 0;

  function automatic void pop_head();
    for (int i = 1; i < n_waiters; i++) waiters[i-1] = waiters[i];
    if (n_waiters != 0) n_waiters--;
  endfunction

  // advance the model by one operation and return the result it produces
  function automatic sem_result_t apply_sem_op(input sem_op_t op);
    sem_result_t r;
    logic        is_head;
    logic        present;
    r = '0;
    if (op.func == FUNC_WAIT) begin
      is_head = (n_waiters != 0) && (waiters[0] == op.task_id);
      if (sem_val != 0 && (n_waiters == 0 || is_head)) begin
        // count taken; a head caller leaves the queue
        sem_val = sem_val - 16'd1;
        if (is_head) pop_head();
        r.granted = 1'b1;
        n_granted++;
      end else begin
        present = 1'b0;
        for (int i = 0; i < n_waiters; i++)
          if (waiters[i] == op.task_id) present = 1'b1;
        // an absent caller joins the tail if there is room
        if (!present && n_waiters < MAX_TASKS_DEF) begin
          waiters[n_waiters] = op.task_id;
          n_waiters++;
        end
        r.caller_blocked = 1'b1;
        n_blocked++;
      end
    end else begin
      if (sem_val != COUNT_MAX) sem_val = sem_val + 16'd1;
      else n_saturated++;
      // dead heads are dropped, the first live one may be woken
      while (n_waiters != 0 && !op.live_mask[waiters[0]]) pop_head();
      if (n_waiters != 0 && op.blocked_mask[waiters[0]]) begin
        r.wake_valid = 1'b1;
        r.wake_task  = waiters[0];
        n_wakes++;
      end
    end
    r.waiter_count = 5'(n_waiters);
    r.sem_count    = sem_val;
    if (n_waiters > max_depth) max_depth = n_waiters;
    return r;
  endfunction

  // offer one beat, with a random gap in front, and return at the accepting edge
  task automatic send_op(input sem_op_t op);
    if ($urandom_range(0, 99) < idle_pct) begin
      cmd_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    cmd_ch.valid        <= 1'b1;
    cmd_ch.func         <= op.func;
    cmd_ch.task_id      <= op.task_id;
    cmd_ch.live_mask    <= op.live_mask;
    cmd_ch.blocked_mask <= op.blocked_mask;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    ops_sent++;
  endtask

  // register write, only once every outstanding result has come back
  task automatic write_initial_count(input logic [15:0] value);
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= INIT_COUNT_ADDR;
    pwdata  <= {16'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    // write lands at this edge: count reloads, queue empties
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sem_val   = value;
    n_waiters = 0;
  endtask

  task automatic check_result();
    sem_result_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: result beat with nothing expected: granted %0b blocked %0b wake %0b/%0d len %0d count %0d",
               $time, res_ch.granted, res_ch.caller_blocked, res_ch.wake_valid,
               res_ch.wake_task, res_ch.waiter_count, res_ch.sem_count);
      fail_count++;
    end else begin
      want = pending_results.pop_front();
      if (res_ch.granted !== want.granted) begin
        $display("%0t: granted expected %0b got %0b", $time, want.granted, res_ch.granted);
        fail_count++;
      end
      if (res_ch.caller_blocked !== want.caller_blocked) begin
        $display("%0t: caller_blocked expected %0b got %0b", $time, want.caller_blocked,
                 res_ch.caller_blocked);
        fail_count++;
      end
      if (res_ch.wake_valid !== want.wake_valid) begin
        $display("%0t: wake_valid expected %0b got %0b", $time, want.wake_valid,
                 res_ch.wake_valid);
        fail_count++;
      end
      if (res_ch.wake_task !== want.wake_task) begin
        $display("%0t: wake_task expected %0d got %0d", $time, want.wake_task, res_ch.wake_task);
        fail_count++;
      end
      if (res_ch.waiter_count !== want.waiter_count) begin
        $display("%0t: waiter_count expected %0d got %0d", $time, want.waiter_count,
                 res_ch.waiter_count);
        fail_count++;
      end
      if (res_ch.sem_count !== want.sem_count) begin
        $display("%0t: sem_count expected %0d got %0d", $time, want.sem_count, res_ch.sem_count);
        fail_count++;
      end
      results_ok++;
    end
  endtask

  // result side: random backpressure, plus a long hold-off whenever one is asked
  initial begin
    int hold_left;
    int holds_served;
    hold_left    = 0;
    holds_served = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid && res_ch.ready) check_result();
      if (rst) begin
        res_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        res_ch.ready <= 1'b0;
        hold_left--;
      end else if (holds_served != holds_asked) begin
        // input side keeps offering meanwhile, so the block backs up
        res_ch.ready <= 1'b0;
        hold_left = HOLD_CYCLES;
        holds_served++;
      end else begin
        res_ch.ready <= ($urandom_range(0, 99) >= idle_pct);
      end
    end
  end

  dir_row_t dir_rows [N_DIR];

  initial begin
    sem_op_t     op;
    sem_result_t got;
    logic [15:0] cfg;
    int          wait_pct;
    int          pool_max;

    // directed walk; count is 0 and the queue is empty out of reset
    dir_rows = '{
      // wait on an empty semaphore: caller queued and blocked
      '{ROW_OP,  '{FUNC_WAIT,   4'd3,  16'h0000, 16'h0000}, 16'h0, 1'b1,
        '{1'b0, 1'b1, 1'b0, 4'd0, 5'd1, 16'd0}},
      // head waits again with no count: stays put
      '{ROW_OP,  '{FUNC_WAIT,   4'd3,  16'hFFFF, 16'hFFFF}, 16'h0, 1'b0, '0},
      '{ROW_OP,  '{FUNC_WAIT,   4'd5,  16'h0000, 16'h0000}, 16'h0, 1'b0, '0},
      // signal wakes the blocked head
      '{ROW_OP,  '{FUNC_SIGNAL, 4'd0,  16'hFFFF, 16'h0008}, 16'h0, 1'b1,
        '{1'b0, 1'b0, 1'b1, 4'd3, 5'd2, 16'd1}},
      // count is there but caller is queued behind the head
      '{ROW_OP,  '{FUNC_WAIT,   4'd5,  16'h0000, 16'h0000}, 16'h0, 1'b0, '0},
      // head takes the count and leaves
      '{ROW_OP,  '{FUNC_WAIT,   4'd3,  16'h0000, 16'h0000}, 16'h0, 1'b0, '0},
      // every waiter dead: queue drains, nothing to wake
      '{ROW_OP,  '{FUNC_SIGNAL, 4'd15, 16'h0000, 16'hFFFF}, 16'h0, 1'b1,
        '{1'b0, 1'b0, 1'b0, 4'd0, 5'd0, 16'd1}},
      '{ROW_OP,  '{FUNC_WAIT,   4'd0,  16'h0000, 16'h0000}, 16'h0, 1'b0, '0},
      // fill the queue with all sixteen ids
      '{ROW_OP,  '{FUNC_WAIT,   4'd15, 16'h0000, 16'h0000}, 16'h0, 1'b0, '0},
      '{ROW_OP,  '{FUNC_WAIT,   4'd14, 16'h0000, 16'h0000}, 16'h0, 1'b0, '0},
      '{ROW_OP,  '{FUNC_WAIT,   4'd13, 16'h0000, 16'h0000}, 16'h0, 1'b0, '0},
      '{ROW_OP,  '{FUNC_WAIT,   4'd12, 16'h0000, 16'h0000}, 16'h0, 1'b0, '0},
      '{ROW_OP,  '{FUNC_WAIT,   4'd11, 16'h0000, 16'h0000}, 16'h0, 1'b0, '0},
      '{ROW_OP,  '{FUNC_WAIT,   4'd10, 16'h0000, 16'h0000}, 16'h0, 1'b0, '0},
      '{ROW_OP,  '{FUNC_WAIT,   4'd9,  16'h0000, 16'h0000}, 16'h0, 1'b0, '0},
      '{ROW_OP,  '{FUNC_WAIT,   4'd8,  16'h0000, 16'h0000}, 16'h0, 1'b0, '0},
      '{ROW_OP,  '{FUNC_WAIT,   4'd7,  16'h0000, 16'h0000}, 16'h0, 1'b0, '0},
      '{ROW_OP,  '{FUNC_WAIT,   4'd6,  16'h0000, 16'h0000}, 16'h0, 1'b0, '0},
      '{ROW_OP,  '{FUNC_WAIT,   4'd5,  16'h0000, 16'h0000}, 16'h0, 1'b0, '0},
      '{ROW_OP,  '{FUNC_WAIT,   4'd4,  16'h0000, 16'h0000}, 16'h0, 1'b0, '0},
      '{ROW_OP,  '{FUNC_WAIT,   4'd3,  16'h0000, 16'h0000}, 16'h0, 1'b0, '0},
      '{ROW_OP,  '{FUNC_WAIT,   4'd2,  16'h0000, 16'h0000}, 16'h0, 1'b0, '0},
      '{ROW_OP,  '{FUNC_WAIT,   4'd1,  16'h0000, 16'h0000}, 16'h0, 1'b0, '0},
      '{ROW_OP,  '{FUNC_WAIT,   4'd0,  16'h0000, 16'h0000}, 16'h0, 1'b1,
        '{1'b0, 1'b1, 1'b0, 4'd0, 5'd16, 16'd0}},
      // fifteen dead heads popped, live head not blocked: no wake
      '{ROW_OP,  '{FUNC_SIGNAL, 4'd0,  16'h0001, 16'h0000}, 16'h0, 1'b1,
        '{1'b0, 1'b0, 1'b0, 4'd0, 5'd1, 16'd1}},
      // count at its top: signal saturates
      '{ROW_CFG, '0, 16'hFFFF, 1'b0, '0},
      '{ROW_OP,  '{FUNC_SIGNAL, 4'd15, 16'hFFFF, 16'hFFFF}, 16'h0, 1'b1,
        '{1'b0, 1'b0, 1'b0, 4'd0, 5'd0, 16'hFFFF}},
      '{ROW_OP,  '{FUNC_WAIT,   4'd9,  16'hFFFF, 16'hFFFF}, 16'h0, 1'b1,
        '{1'b1, 1'b0, 1'b0, 4'd0, 5'd0, 16'hFFFE}}
    };

    rst                 <= 1'b1;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    cmd_ch.valid        <= 1'b0;
    cmd_ch.func         <= FUNC_WAIT;
    cmd_ch.task_id      <= '0;
    cmd_ch.live_mask    <= '0;
    cmd_ch.blocked_mask <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_initial_count(dir_rows[i].cfg_value);
      end else begin
        send_op(dir_rows[i].op);
        got = apply_sem_op(dir_rows[i].op);
        pending_results.push_back(dir_rows[i].typed ? dir_rows[i].want : got);
      end
    end

    // random phases, each from a fresh starting count
    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0:       cfg = 16'd0;
        1:       cfg = 16'($urandom_range(1, 3));
        2:       cfg = COUNT_MAX;
        3:       cfg = 16'($urandom_range(0, 8));
        4:       cfg = COUNT_MAX - 16'd1;
        default: cfg = 16'($urandom);
      endcase
      write_initial_count(cfg);
      // phase 3 runs with no random gaps on either side
      idle_pct = (p == 3) ? 0 : 29;
      wait_pct = (p == 0) ? 65 : 55;
      pool_max = (p == 0 || p == 5) ? 15 : 7;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ((p == 1 || p == 3) && n == 20) holds_asked++;
        op.func = ($urandom_range(0, 99) < wait_pct) ? FUNC_WAIT : FUNC_SIGNAL;
        // a woken head coming back one time in three, else mostly a caller from a small pool
        if (n_waiters != 0 && $urandom_range(0, 2) == 0) op.task_id = waiters[0];
        else if ($urandom_range(0, 7) == 0) op.task_id = 4'($urandom);
        else op.task_id = 4'($urandom_range(0, pool_max));
        case ($urandom_range(0, 4))
          0: op.live_mask = 16'($urandom);
          1, 2: begin
            op.live_mask = '1;
            op.live_mask[$urandom_range(0, 15)] = 1'b0;
            if (n_waiters != 0 && $urandom_range(0, 1) == 0) op.live_mask[waiters[0]] = 1'b0;
          end
          default: op.live_mask = '1;
        endcase
        if ($urandom_range(0, 3) == 0) begin
          op.blocked_mask = 16'($urandom);
        end else begin
          // queued tasks are the blocked ones
          op.blocked_mask = '0;
          for (int i = 0; i < n_waiters; i++) op.blocked_mask[waiters[i]] = 1'b1;
        end
        send_op(op);
        pending_results.push_back(apply_sem_op(op));
      end
    end

    cmd_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d operations, %0d results compared: %0d grants, %0d blocks, %0d wakes",
             ops_sent, results_ok, n_granted, n_blocked, n_wakes);
    $display("deepest queue %0d, %0d saturated signals, %0d mismatches",
             max_depth, n_saturated, fail_count);
    if (fail_count == 0) begin
      $display("[counting_semaphore_fifo_waiters] OK");
    end else begin
      $display("[counting_semaphore_fifo_waiters] ERROR");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("%0t: run did not finish, %0d results still outstanding", $time,
             pending_results.size());
    $display("[counting_semaphore_fifo_waiters] ERROR");
    $finish;
  end

endmodule
